// ===== src/bcodec_pkg.sv =====
package bcodec_pkg;

  localparam int unsigned AddrW = 3;
  localparam int unsigned DataW = 32;
  localparam logic RegDirection = 1'b0;

  typedef enum logic {
    DirEncode = 1'b0,
    DirDecode = 1'b1
  } dir_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       in_last;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_word_t;

  // One queued job: one or two result words produced by a single input word.
  typedef struct packed {
    logic       two;
    logic [7:0] w0;
    logic [7:0] w1;
    logic       last;
  } job_t;

  function automatic logic [7:0] enc_char(input logic [5:0] v);
    logic [7:0] x;
    x = {2'b00, v};
    if (v < 6'd26) begin
      enc_char = x + 8'd65;
    end else if (v < 6'd52) begin
      enc_char = x + 8'd71;
    end else if (v < 6'd62) begin
      enc_char = x - 8'd4;
    end else if (v == 6'd62) begin
      enc_char = 8'd43;
    end else begin
      enc_char = 8'd47;
    end
  endfunction

  // Characters outside the alphabet decode to the same value as '/'.
  function automatic logic [5:0] dec_value(input logic [7:0] c);
    logic [7:0] x;
    x = 8'd63;
    if (c >= 8'd65 && c <= 8'd90) begin
      x = c - 8'd65;
    end else if (c >= 8'd97 && c <= 8'd122) begin
      x = c - 8'd71;
    end else if (c >= 8'd48 && c <= 8'd57) begin
      x = c + 8'd4;
    end else if (c == 8'd43) begin
      x = 8'd62;
    end
    dec_value = x[5:0];
  endfunction

endpackage

// ===== src/bcodec_front.sv =====
module bcodec_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bcodec_pkg::dir_e    dir_i,
  input  logic                clear_i,
  input  logic                push_i,
  input  logic                full_i,
  input  bcodec_pkg::in_word_t in_data_i,
  output logic                enq_o,
  output bcodec_pkg::job_t    job_o
);

  logic [5:0] bits_q, bits_d;
  logic [2:0] cnt_q, cnt_d;
  logic [5:0] rem_bits;
  logic [2:0] rem_cnt;
  logic [1:0] num;
  logic [5:0] c0, c1, v;
  logic [7:0] b;
  logic       acc;

  assign acc = push_i && !full_i;
  assign b   = in_data_i.data_byte;
  assign v   = bcodec_pkg::dec_value(b);

  always_comb begin
    num      = 2'd0;
    c0       = '0;
    c1       = '0;
    rem_bits = '0;
    rem_cnt  = '0;
    job_o    = '0;
    if (dir_i == bcodec_pkg::DirEncode) begin
      case (cnt_q)
        3'd2: begin
          c0       = {bits_q[1:0], b[7:4]};
          c1       = {b[3:0], 2'b00};
          rem_bits = {2'b00, b[3:0]};
          rem_cnt  = 3'd4;
          num      = in_data_i.in_last ? 2'd2 : 2'd1;
        end
        3'd4: begin
          c0       = {bits_q[3:0], b[7:6]};
          c1       = b[5:0];
          rem_cnt  = 3'd0;
          num      = 2'd2;
        end
        default: begin
          c0       = b[7:2];
          c1       = {b[1:0], 4'b0000};
          rem_bits = {4'b0000, b[1:0]};
          rem_cnt  = 3'd2;
          num      = in_data_i.in_last ? 2'd2 : 2'd1;
        end
      endcase
      job_o.w0 = bcodec_pkg::enc_char(c0);
      job_o.w1 = bcodec_pkg::enc_char(c1);
    end else begin
      case (cnt_q)
        3'd2: begin
          job_o.w0 = {bits_q[1:0], v};
          rem_cnt  = 3'd0;
          num      = 2'd1;
        end
        3'd4: begin
          job_o.w0 = {bits_q[3:0], v[5:2]};
          rem_bits = {4'b0000, v[1:0]};
          rem_cnt  = 3'd2;
          num      = 2'd1;
        end
        3'd6: begin
          job_o.w0 = {bits_q[5:0], v[5:4]};
          rem_bits = {2'b00, v[3:0]};
          rem_cnt  = 3'd4;
          num      = 2'd1;
        end
        default: begin
          rem_bits = v;
          rem_cnt  = 3'd6;
          num      = 2'd0;
        end
      endcase
    end
    job_o.two  = (num == 2'd2);
    job_o.last = in_data_i.in_last;
  end

  assign enq_o = acc && (num != 2'd0);

  always_comb begin
    bits_d = bits_q;
    cnt_d  = cnt_q;
    if (clear_i) begin
      bits_d = '0;
      cnt_d  = '0;
    end else if (acc) begin
      if (in_data_i.in_last) begin
        bits_d = '0;
        cnt_d  = '0;
      end else begin
        bits_d = rem_bits;
        cnt_d  = rem_cnt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q <= '0;
      cnt_q  <= '0;
    end else begin
      bits_q <= bits_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// ===== src/bcodec_queue.sv =====
module bcodec_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             enq_i,
  input  bcodec_pkg::job_t job_i,
  input  logic             deq_i,
  output logic             valid_o,
  output logic             full_o,
  output bcodec_pkg::job_t job_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  bcodec_pkg::job_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign valid_o = (count_q != '0);
  assign full_o  = (count_q == CntW'(Depth));
  assign job_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (enq_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (deq_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (enq_i && !deq_i) begin
      count_d = count_q + 1'b1;
    end else if (deq_i && !enq_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== src/bcodec_back.sv =====
module bcodec_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  job_valid_i,
  input  bcodec_pkg::job_t      job_i,
  output logic                  deq_o,
  input  logic                  pop_i,
  output logic                  empty_o,
  output bcodec_pkg::out_word_t out_data_o
);

  logic                  sel_q, sel_d;
  logic                  out_valid_q, out_valid_d;
  bcodec_pkg::out_word_t out_q, out_d;
  logic                  taken, load, final_word;

  assign taken      = pop_i && out_valid_q;
  assign load       = job_valid_i && (!out_valid_q || taken);
  // The second word of a job, or the only one, closes the job.
  assign final_word = !job_i.two || sel_q;
  assign deq_o      = load && final_word;

  always_comb begin
    sel_d       = sel_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (load) begin
      out_d.out_byte = sel_q ? job_i.w1 : job_i.w0;
      out_d.out_last = job_i.last && final_word;
      out_valid_d    = 1'b1;
      sel_d          = !final_word;
    end else if (taken) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      sel_q       <= sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign empty_o    = !out_valid_q;
  assign out_data_o = out_q;

endmodule

// ===== src/base64_codec_top.sv =====
// Streaming Base64 codec, standard alphabet, no '=' padding.
// Input words (a byte or a character, plus in_last) enter on push when full
// is low. Results leave on the result ports while empty is low and are taken
// with pop. The direction register (address 0) picks encode (0) or decode (1);
// writing it clears the bit buffer and must only happen while the block idles.
// An input word with in_last set flushes the buffer: encoding pads leftover
// bits with zeros into one more character, decoding drops them. out_last marks
// the final result of such a word.
// Results of accepted words pass through the job queue and the output register
// to the result ports. A word may be accepted every cycle while full is low;
// the port delivers one word per cycle while pop is high, so encoding (four
// characters per three bytes) is port-bound and decoding sustains one character
// per cycle. The job queue holds QueueDepth jobs of up to two results each.
// When pop stays low the output register holds, the queue fills and full rises.
// Reset selects encode, empties the bit buffer, the queue and the output.
module base64_codec_top #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  bcodec_pkg::in_word_t           in_data_i,
  output logic                           empty,
  input  logic                           pop,
  output bcodec_pkg::out_word_t          out_data_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bcodec_pkg::AddrW-1:0]   paddr,
  input  logic [bcodec_pkg::DataW-1:0]   pwdata,
  output logic [bcodec_pkg::DataW-1:0]   prdata,
  output logic                           pready
);

  bcodec_pkg::dir_e dir_q, dir_d;
  logic             cfg_wr, dir_wr;
  logic             enq, deq, job_valid;
  bcodec_pkg::job_t job_in, job_out;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign dir_wr = cfg_wr && (paddr[bcodec_pkg::AddrW-1:2] == bcodec_pkg::RegDirection);

  always_comb begin
    dir_d = dir_q;
    if (dir_wr) begin
      dir_d = bcodec_pkg::dir_e'(pwdata[0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= bcodec_pkg::DirEncode;
    end else begin
      dir_q <= dir_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[bcodec_pkg::AddrW-1:2] == bcodec_pkg::RegDirection) begin
      prdata = {{(bcodec_pkg::DataW-1){1'b0}}, dir_q};
    end
  end

  bcodec_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .dir_i     (dir_q),
    .clear_i   (dir_wr),
    .push_i    (push),
    .full_i    (full),
    .in_data_i (in_data_i),
    .enq_o     (enq),
    .job_o     (job_in)
  );

  bcodec_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .enq_i   (enq),
    .job_i   (job_in),
    .deq_i   (deq),
    .valid_o (job_valid),
    .full_o  (full),
    .job_o   (job_out)
  );

  bcodec_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job_out),
    .deq_o       (deq),
    .pop_i       (pop),
    .empty_o     (empty),
    .out_data_o  (out_data_o)
  );

`ifndef ASSERT_OFF
  a_deq_needs_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    deq |-> job_valid)
    else $error("job dequeued from an empty queue");

  a_full_has_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> job_valid)
    else $error("queue reports full without a job");

  a_drain_to_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && !job_valid) |=> empty)
    else $error("output stayed valid after its last word was taken");
`endif

endmodule
